// ----- sv/ssp_pkg.sv -----
// shared types and constants for the sphere surface projection unit
// no dependencies; imported by sphere_surface_projection_unit
`default_nettype none
package ssp_pkg;

  localparam int COORD_BITS = 32;
  // root of a three-term sum of squares needs one bit more than a coordinate
  localparam int ROOT_BITS  = COORD_BITS + 1;
  localparam int RAD_BITS   = 2 * ROOT_BITS;
  localparam int SQ_STEPS   = ROOT_BITS;
  // quotient never exceeds the radius, so one coordinate width of steps
  localparam int DIV_STEPS  = COORD_BITS;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int CFG_BITS   = 32;
  localparam int IDX_BITS   = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [ROOT_BITS-1:0]         root_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Y = 3'd1,
    REG_CENTRE_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_DIMS     = 3'd4,
    REG_LIMIT    = 3'd5,
    REG_TOL      = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] DIMS_3D = 2'd3;
  localparam logic [1:0] DIMS_2D = 2'd2;

  // per-item data carried down the whole pipeline
  typedef struct packed {
    coord_t     px;
    coord_t     py;
    coord_t     pz;
    logic       dim_err;
    logic       is3d;
    logic [2:0] neg;
    mag_t       mx;
    mag_t       my;
    mag_t       mz;
  } item_t;

endpackage
`default_nettype wire

// ----- sv/sphere_surface_projection_unit.sv -----
// sphere surface projection: top level, full pipeline with all arithmetic
// depends on ssp_pkg for types, widths and register indexes
// pipeline: accepted input beat to output beat through 3 front stages,
// 33 root stages, 2 product stages, 32 divide stages and 1 output stage
// throughput: one beat per cycle while the output beat is not stalled; the
// pipeline freezes as one while the output beat is stalled
// reset: synchronous active low, clears valid bits and loads register defaults
`default_nettype none
module sphere_surface_projection_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire ssp_pkg::coord_t          in_point_x,
  input  wire ssp_pkg::coord_t          in_point_y,
  input  wire ssp_pkg::coord_t          in_point_z,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output ssp_pkg::coord_t               out_moved_x,
  output ssp_pkg::coord_t               out_moved_y,
  output ssp_pkg::coord_t               out_moved_z,
  output logic                          out_off_surface,
  output logic                          out_at_centre,
  output logic                          out_dimension_error,
  input  wire logic                     cfg_we,
  input  wire logic [ssp_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [ssp_pkg::CFG_BITS-1:0] cfg_data
);
  import ssp_pkg::*;

  // configuration registers
  coord_t      centre_x_r, centre_y_r, centre_z_r;
  logic [30:0] radius_r;
  logic [1:0]  dims_r;
  logic [15:0] limit_r, tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
      radius_r   <= 31'd65536;
      dims_r     <= DIMS_3D;
      limit_r    <= 16'd1;
      tol_r      <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_CENTRE_X: centre_x_r <= coord_t'(cfg_data);
        REG_CENTRE_Y: centre_y_r <= coord_t'(cfg_data);
        REG_CENTRE_Z: centre_z_r <= coord_t'(cfg_data);
        REG_RADIUS:   radius_r   <= cfg_data[30:0];
        REG_DIMS:     dims_r     <= cfg_data[1:0];
        REG_LIMIT:    limit_r    <= cfg_data[15:0];
        REG_TOL:      tol_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output beat is held
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // front: differences and magnitudes
  logic              v1_r;
  item_t             it1_r, it1_nxt;
  logic signed [COORD_BITS:0] dx, dy, dz;

  always_comb begin
    dx = {in_point_x[COORD_BITS-1], in_point_x} - {centre_x_r[COORD_BITS-1], centre_x_r};
    dy = {in_point_y[COORD_BITS-1], in_point_y} - {centre_y_r[COORD_BITS-1], centre_y_r};
    dz = (dims_r == DIMS_3D)
       ? {in_point_z[COORD_BITS-1], in_point_z} - {centre_z_r[COORD_BITS-1], centre_z_r}
       : '0;
    it1_nxt.px      = in_point_x;
    it1_nxt.py      = in_point_y;
    it1_nxt.pz      = in_point_z;
    it1_nxt.dim_err = (dims_r != DIMS_3D) && (dims_r != DIMS_2D);
    it1_nxt.is3d    = (dims_r == DIMS_3D);
    it1_nxt.neg     = {dz[COORD_BITS], dy[COORD_BITS], dx[COORD_BITS]};
    it1_nxt.mx      = dx[COORD_BITS] ? mag_t'(-dx) : mag_t'(dx);
    it1_nxt.my      = dy[COORD_BITS] ? mag_t'(-dy) : mag_t'(dy);
    it1_nxt.mz      = dz[COORD_BITS] ? mag_t'(-dz) : mag_t'(dz);
  end

  // squares
  logic                 v2_r;
  item_t                it2_r;
  logic [PROD_BITS-1:0] sqx_r, sqy_r, sqz_r;
  // sum of squares
  logic                 v3_r;
  item_t                it3_r;
  logic [RAD_BITS-1:0]  sum_r;

  // root chain: two radicand bits per stage
  logic                v_sq_r    [SQ_STEPS];
  item_t               it_sq_r   [SQ_STEPS];
  logic [RAD_BITS-1:0] rad_sq_r  [SQ_STEPS];
  logic [ROOT_BITS+1:0] rem_sq_r [SQ_STEPS];
  root_t               root_sq_r [SQ_STEPS];
  logic [RAD_BITS-1:0] rad_sq_nxt  [SQ_STEPS];
  logic [ROOT_BITS+1:0] rem_sq_nxt [SQ_STEPS];
  root_t               root_sq_nxt [SQ_STEPS];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      logic [RAD_BITS-1:0]  rad_in;
      logic [ROOT_BITS+1:0] rem_in;
      root_t                root_in;
      logic [ROOT_BITS+3:0] acc, trial;
      rad_in  = (k == 0) ? sum_r : rad_sq_r[(k == 0) ? 0 : k-1];
      rem_in  = (k == 0) ? '0    : rem_sq_r[(k == 0) ? 0 : k-1];
      root_in = (k == 0) ? '0    : root_sq_r[(k == 0) ? 0 : k-1];
      acc   = {rem_in, rad_in[RAD_BITS-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      rad_sq_nxt[k] = {rad_in[RAD_BITS-3:0], 2'b00};
      if (acc >= trial) begin
        rem_sq_nxt[k]  = (ROOT_BITS+2)'(acc - trial);
        root_sq_nxt[k] = {root_in[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_sq_nxt[k]  = (ROOT_BITS+2)'(acc);
        root_sq_nxt[k] = {root_in[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // flags and radius products
  logic                 v4_r;
  item_t                it4_r;
  root_t                d4_r;
  logic                 off4_r, at4_r;
  logic [PROD_BITS-1:0] p4_r [3];
  root_t                d_sq, err_d;
  assign d_sq  = root_sq_r[SQ_STEPS-1];
  assign err_d = (d_sq > root_t'(radius_r)) ? d_sq - root_t'(radius_r)
                                             : root_t'(radius_r) - d_sq;

  // add half divisor, set up division
  logic                 v5_r;
  item_t                it5_r;
  root_t                d5_r;
  logic                 off5_r, at5_r;
  logic [PROD_BITS-1:0] num5_r [3];

  // divide chain: one quotient bit per stage per lane
  logic        v_dv_r   [DIV_STEPS];
  item_t       it_dv_r  [DIV_STEPS];
  root_t       d_dv_r   [DIV_STEPS];
  logic        off_dv_r [DIV_STEPS];
  logic        at_dv_r  [DIV_STEPS];
  root_t       rem_dv_r [DIV_STEPS][3];
  mag_t        low_dv_r [DIV_STEPS][3];
  mag_t        q_dv_r   [DIV_STEPS][3];
  root_t       rem_dv_nxt [DIV_STEPS][3];
  mag_t        low_dv_nxt [DIV_STEPS][3];
  mag_t        q_dv_nxt   [DIV_STEPS][3];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < 3; l++) begin
        root_t            rem_in, den;
        mag_t             low_in, q_in;
        logic [ROOT_BITS:0] acc;
        rem_in = (k == 0) ? root_t'(num5_r[l][PROD_BITS-1:COORD_BITS])
                          : rem_dv_r[(k == 0) ? 0 : k-1][l];
        low_in = (k == 0) ? num5_r[l][COORD_BITS-1:0] : low_dv_r[(k == 0) ? 0 : k-1][l];
        q_in   = (k == 0) ? '0 : q_dv_r[(k == 0) ? 0 : k-1][l];
        den    = (k == 0) ? d5_r : d_dv_r[(k == 0) ? 0 : k-1];
        acc    = {rem_in, low_in[COORD_BITS-1]};
        low_dv_nxt[k][l] = {low_in[COORD_BITS-2:0], 1'b0};
        if (acc >= {1'b0, den}) begin
          rem_dv_nxt[k][l] = root_t'(acc - {1'b0, den});
          q_dv_nxt[k][l]   = {q_in[COORD_BITS-2:0], 1'b1};
        end else begin
          rem_dv_nxt[k][l] = root_t'(acc);
          q_dv_nxt[k][l]   = {q_in[COORD_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // final: centre plus signed quotient, saturate, select pass-through
  item_t it_f;
  mag_t  qf [3];
  coord_t mv_nxt [3];
  coord_t cen [3];
  always_comb begin
    it_f = it_dv_r[DIV_STEPS-1];
    cen[0] = centre_x_r;
    cen[1] = centre_y_r;
    cen[2] = centre_z_r;
    for (int l = 0; l < 3; l++) begin
      logic signed [COORD_BITS+1:0] s;
      qf[l] = q_dv_r[DIV_STEPS-1][l];
      s = it_f.neg[l] ? {{2{cen[l][COORD_BITS-1]}}, cen[l]} - {2'b00, qf[l]}
                      : {{2{cen[l][COORD_BITS-1]}}, cen[l]} + {2'b00, qf[l]};
      if (s > (COORD_BITS+2)'(signed'({2'b00, {(COORD_BITS-1){1'b1}}})))
        mv_nxt[l] = {1'b0, {(COORD_BITS-1){1'b1}}};
      else if (s < -(COORD_BITS+2)'(signed'({2'b00, 1'b1, {(COORD_BITS-1){1'b0}}})))
        mv_nxt[l] = {1'b1, {(COORD_BITS-1){1'b0}}};
      else
        mv_nxt[l] = coord_t'(s);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < SQ_STEPS; k++) v_sq_r[k] <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) v_dv_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v_sq_r[0] <= v3_r;
      for (int k = 1; k < SQ_STEPS; k++) v_sq_r[k] <= v_sq_r[k-1];
      v4_r <= v_sq_r[SQ_STEPS-1];
      v5_r <= v4_r;
      v_dv_r[0] <= v5_r;
      for (int k = 1; k < DIV_STEPS; k++) v_dv_r[k] <= v_dv_r[k-1];
      out_valid <= v_dv_r[DIV_STEPS-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r <= it1_nxt;
      it2_r <= it1_r;
      sqx_r <= PROD_BITS'(it1_r.mx) * PROD_BITS'(it1_r.mx);
      sqy_r <= PROD_BITS'(it1_r.my) * PROD_BITS'(it1_r.my);
      sqz_r <= PROD_BITS'(it1_r.mz) * PROD_BITS'(it1_r.mz);
      it3_r <= it2_r;
      sum_r <= RAD_BITS'(sqx_r) + RAD_BITS'(sqy_r) + RAD_BITS'(sqz_r);
      it_sq_r[0] <= it3_r;
      for (int k = 1; k < SQ_STEPS; k++) it_sq_r[k] <= it_sq_r[k-1];
      for (int k = 0; k < SQ_STEPS; k++) begin
        rad_sq_r[k]  <= rad_sq_nxt[k];
        rem_sq_r[k]  <= rem_sq_nxt[k];
        root_sq_r[k] <= root_sq_nxt[k];
      end
      // flags and products
      it4_r  <= it_sq_r[SQ_STEPS-1];
      d4_r   <= d_sq;
      off4_r <= err_d > root_t'(tol_r);
      at4_r  <= d_sq <= root_t'(limit_r);
      p4_r[0] <= PROD_BITS'(radius_r) * PROD_BITS'(it_sq_r[SQ_STEPS-1].mx);
      p4_r[1] <= PROD_BITS'(radius_r) * PROD_BITS'(it_sq_r[SQ_STEPS-1].my);
      p4_r[2] <= PROD_BITS'(radius_r) * PROD_BITS'(it_sq_r[SQ_STEPS-1].mz);
      it5_r  <= it4_r;
      d5_r   <= d4_r;
      off5_r <= off4_r;
      at5_r  <= at4_r;
      for (int l = 0; l < 3; l++) num5_r[l] <= p4_r[l] + PROD_BITS'(d4_r >> 1);
      // divide chain
      it_dv_r[0]  <= it5_r;
      d_dv_r[0]   <= d5_r;
      off_dv_r[0] <= off5_r;
      at_dv_r[0]  <= at5_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        it_dv_r[k]  <= it_dv_r[k-1];
        d_dv_r[k]   <= d_dv_r[k-1];
        off_dv_r[k] <= off_dv_r[k-1];
        at_dv_r[k]  <= at_dv_r[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        for (int l = 0; l < 3; l++) begin
          rem_dv_r[k][l] <= rem_dv_nxt[k][l];
          low_dv_r[k][l] <= low_dv_nxt[k][l];
          q_dv_r[k][l]   <= q_dv_nxt[k][l];
        end
      end
      // output beat
      if (it_f.dim_err) begin
        out_moved_x         <= it_f.px;
        out_moved_y         <= it_f.py;
        out_moved_z         <= it_f.pz;
        out_off_surface     <= 1'b0;
        out_at_centre       <= 1'b0;
        out_dimension_error <= 1'b1;
      end else begin
        out_moved_x         <= at_dv_r[DIV_STEPS-1] ? it_f.px : mv_nxt[0];
        out_moved_y         <= at_dv_r[DIV_STEPS-1] ? it_f.py : mv_nxt[1];
        out_moved_z         <= (at_dv_r[DIV_STEPS-1] || !it_f.is3d) ? it_f.pz : mv_nxt[2];
        out_off_surface     <= off_dv_r[DIV_STEPS-1];
        out_at_centre       <= at_dv_r[DIV_STEPS-1];
        out_dimension_error <= 1'b0;
      end
    end
  end

  // checks
  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dimension_error |-> !out_at_centre && !out_off_surface)
    else $error("dimension error beat carries other flags");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

endmodule
`default_nettype wire

// ----- bench/sphere_surface_projection_unit_tb.sv -----
// testbench for sphere_surface_projection_unit: directed and random points,
// scoreboard fed by an in-bench projection predictor; depends on ssp_pkg
`default_nettype none
module sphere_surface_projection_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssp_pkg::*;

  typedef struct {
    logic signed [31:0] x, y, z;
  } point_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic off_surf, at_ctr, dim_err;
  } moved_t;

  localparam int LATENCY = 71;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_moved_x, out_moved_y, out_moved_z;
  logic out_off_surface, out_at_centre, out_dimension_error;
  logic cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  sphere_surface_projection_unit dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0] radius;
  logic [1:0] dims;
  logic [15:0] near_limit, tolerance;

  point_t pending_points[$];
  moved_t expected_moves[$];
  int errors = 0;
  int accepted_in = 0, accepted_out = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_out = 1'b0;
  int hold_count = 0;
  int n_at_ctr = 0, n_off = 0, n_dimerr = 0;

  function automatic logic [63:0] int_sqrt(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] project_coord(logic signed [63:0] c,
      logic signed [63:0] delta, logic [63:0] d);
    logic [127:0] num;
    logic [63:0] mag;
    logic signed [127:0] q, v;
    mag = delta < 0 ? -delta : delta;
    num = {97'd0, radius} * {64'd0, mag} + {64'd0, d >> 1};
    q = num / {64'd0, d};
    v = delta < 0 ? c - q : c + q;
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic moved_t predict_move(point_t p);
    moved_t m;
    logic signed [63:0] dx, dy, dz;
    logic [127:0] ax, ay, az;
    logic [127:0] s;
    logic [63:0] d, err;
    m.x = p.x; m.y = p.y; m.z = p.z;
    m.off_surf = 0; m.at_ctr = 0; m.dim_err = 0;
    if (dims < 2) begin
      m.dim_err = 1;
      return m;
    end
    dx = 64'(p.x) - 64'(ctr_x);
    dy = 64'(p.y) - 64'(ctr_y);
    dz = dims == DIMS_3D ? 64'(p.z) - 64'(ctr_z) : 64'sd0;
    // squares of magnitudes, exact in 128 bits
    ax = {64'd0, dx < 0 ? -dx : dx};
    ay = {64'd0, dy < 0 ? -dy : dy};
    az = {64'd0, dz < 0 ? -dz : dz};
    s = ax * ax + ay * ay + az * az;
    d = int_sqrt(s);
    err = d > radius ? d - radius : radius - d;
    m.off_surf = err > tolerance;
    if (d <= near_limit) begin
      m.at_ctr = 1;
      return m;
    end
    m.x = project_coord(ctr_x, dx, d);
    m.y = project_coord(ctr_y, dy, d);
    if (dims == DIMS_3D) m.z = project_coord(ctr_z, dz, d);
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at beat %0d: %s got %h expected %h", accepted_out, what, got, want);
    errors++;
  endtask

  // driver: offers the next point, random gaps
  int gap = 0;
  bit pause_in = 1'b0;
  always @(posedge clk) begin
    if (in_valid && !in_stall) accepted_in++;
    if (!in_valid || !in_stall) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (!pause_in && pending_points.size() > 0 &&
                   !(in_valid && !in_stall && pending_points.size() == 0)) begin
        point_t p;
        p = pending_points.pop_front();
        expected_moves.push_back(predict_move(p));
        in_point_x <= p.x; in_point_y <= p.y; in_point_z <= p.z;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts, plus a long hold-off on request
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    moved_t e;
    if (rst_n && out_valid && !out_stall) begin
      accepted_out++;
      if (expected_moves.size() == 0) begin
        report_mismatch("unexpected beat, moved_x", out_moved_x, '0);
      end else begin
        e = expected_moves.pop_front();
        if (out_moved_x !== e.x) report_mismatch("moved_x", out_moved_x, e.x);
        if (out_moved_y !== e.y) report_mismatch("moved_y", out_moved_y, e.y);
        if (out_moved_z !== e.z) report_mismatch("moved_z", out_moved_z, e.z);
        if (out_off_surface !== e.off_surf)
          report_mismatch("off_surface", out_off_surface, e.off_surf);
        if (out_at_centre !== e.at_ctr) report_mismatch("at_centre", out_at_centre, e.at_ctr);
        if (out_dimension_error !== e.dim_err)
          report_mismatch("dimension_error", out_dimension_error, e.dim_err);
        n_at_ctr += e.at_ctr; n_off += e.off_surf; n_dimerr += e.dim_err;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_out)
      idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("sphere_surface_projection_unit_tb failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTRE_X: ctr_x = value;
      REG_CENTRE_Y: ctr_y = value;
      REG_CENTRE_Z: ctr_z = value;
      REG_RADIUS:   radius = value[30:0];
      REG_DIMS:     dims = value[1:0];
      REG_LIMIT:    near_limit = value[15:0];
      REG_TOL:      tolerance = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_moves.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 400)) - 200);
      default: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff);
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endtask

  // points: some close to the centre, some exactly on the sphere, the rest random
  task automatic add_random_points(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        add_point(ctr_x + 32'($signed($urandom_range(0, 6)) - 3),
                  ctr_y + 32'($signed($urandom_range(0, 6)) - 3),
                  ctr_z + 32'($signed($urandom_range(0, 6)) - 3));
      else if ($urandom_range(0, 3) == 0)
        add_point(ctr_x + radius, ctr_y, ctr_z);
      else
        add_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    ctr_x = 0; ctr_y = 0; ctr_z = 0; radius = 31'd65536; dims = DIMS_3D;
    near_limit = 16'd1; tolerance = 16'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: defaults, extremes, near centre, on surface
    add_point(0, 0, 0);
    add_point(1, 0, 0);
    add_point(2, 0, 0);
    add_point(32'h10000, 0, 0);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
    add_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_point(-32'sd3, 32'd4, 0);
    drain();
    // saturation: large radius, centre at an extreme
    write_reg(REG_CENTRE_X, 32'h7fff0000);
    write_reg(REG_CENTRE_Y, 32'h80000000);
    write_reg(REG_CENTRE_Z, 32'h00001234);
    write_reg(REG_RADIUS, 32'h7fffffff);
    write_reg(REG_LIMIT, 16'hffff);
    write_reg(REG_TOL, 16'hffff);
    add_point(32'h80000000, 32'h7fffffff, 0);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h80000000);
    add_point(32'h7fff0000, 32'h80000000, 32'h00001234);
    add_point(32'h7fff8000, 32'h80000000, 32'h00001234);
    drain();
    // 2d and dimension error
    write_reg(REG_DIMS, DIMS_2D);
    write_reg(REG_RADIUS, 1);
    write_reg(REG_LIMIT, 0);
    write_reg(REG_TOL, 0);
    add_point(32'h7fff0001, 32'h80000000, 32'h55555555);
    add_point(0, 0, 32'haaaaaaaa);
    drain();
    write_reg(REG_DIMS, 2'd1);
    add_point(32'h12345678, 32'h9abcdef0, 32'hffffffff);
    drain();
    write_reg(REG_DIMS, 2'd0);
    add_point(32'h80000000, 32'h7fffffff, 0);
    drain();

    // random phases with several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CENTRE_X, ph == 0 ? 0 : rand_coord());
      write_reg(REG_CENTRE_Y, ph == 0 ? 0 : rand_coord());
      write_reg(REG_CENTRE_Z, ph == 0 ? 0 : rand_coord());
      write_reg(REG_RADIUS, ph == 1 ? 32'h7fffffff : ph == 2 ? 1 : $urandom_range(1, 32'h3ffff));
      write_reg(REG_DIMS, ph == 5 ? 2'd1 : ph[0] ? DIMS_2D : DIMS_3D);
      write_reg(REG_LIMIT, ph == 3 ? 16'hffff : $urandom_range(0, 8));
      write_reg(REG_TOL, ph == 4 ? 16'hffff : $urandom_range(0, 20));
      if (ph == 5) calm = 1'b1;
      add_random_points(ph == 5 ? 100 : 130);
      if (ph == 2) begin
        // long receiver hold-off while points keep coming
        hold_out = 1'b1;
        while (hold_count < 150) @(posedge clk);
        hold_out = 1'b0;
      end
      if (ph == 3) begin
        // sender waits for all results mid-phase
        repeat (40) @(posedge clk);
        pause_in = 1'b1;
        while (expected_moves.size() > 0 || in_valid) @(posedge clk);
        pause_in = 1'b0;
      end
      drain();
    end

    $display("covered %0d points in 2d, 3d and error modes, %0d results checked",
             accepted_in, accepted_out);
    $display("flags seen: at_centre %0d, off_surface %0d, dimension_error %0d",
             n_at_ctr, n_off, n_dimerr);
    if (errors == 0 && expected_moves.size() == 0)
      $display("sphere_surface_projection_unit_tb passed");
    else
      $display("sphere_surface_projection_unit_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
